FILE: sv/plst_pkg.sv
// ----------------------------------------------------------------------------
// plst_pkg: shared types for the positional list engine
// operation and status codes, field widths, controller/datapath interface
// ----------------------------------------------------------------------------
package plst_pkg;

    // fixed field widths of the command and result beats
    localparam int OP_W        = 3;
    localparam int POS_W       = 7;
    localparam int ENTRY_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;

    // command codes, code 7 is unused and treated as a no-op
    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_REM_FRONT = 3'd3,
        OP_REM_BACK  = 3'd4,
        OP_REM_AT    = 3'd5,
        OP_READ_AT   = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // command class after decode
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    // controller -> datapath commands
    typedef struct packed {
        logic accept;       // latch and decode incoming beat
        logic rd_target;    // read memory at target position
        logic rd_move;      // read memory at shift source
        logic wr_move;      // write shifted entry, step shift index
        logic wr_place;     // write new handle at target position
        logic keep_got;     // capture read data as result handle
        logic load_result;  // load output register, update count
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic  ok;          // command passed its checks
        kind_t kind;
        logic  move_more;   // a shift step remains at current index
        logic  move_last;   // current shift step is the final one
    } stat_t;

endpackage

FILE: sv/plst_dpath.sv
// ----------------------------------------------------------------------------
// plst_dpath: list storage, count and shift datapath
// decodes commands, holds the handle memory and moves entries one at a time
// ----------------------------------------------------------------------------
module plst_dpath #(
    parameter int DEPTH       = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [plst_pkg::OP_W-1:0]         operation,
    input  logic [plst_pkg::POS_W-1:0]        position,
    input  logic [plst_pkg::ENTRY_W-1:0]      entry,
    input  plst_pkg::cmd_t                    cmd,
    output plst_pkg::stat_t                   stat,
    output logic [plst_pkg::STATUS_W-1:0]     status,
    output logic [plst_pkg::ENTRY_W-1:0]      removed_entry,
    output logic [plst_pkg::COUNT_OUT_W-1:0]  entry_count
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = ((CW > plst_pkg::POS_W) ? CW : plst_pkg::POS_W) + 1;

    logic [HANDLE_BITS-1:0] mem [DEPTH];

    logic [CW-1:0]           count_reg, count_next;
    plst_pkg::kind_t         kind_reg;
    plst_pkg::status_t       st_reg;
    logic [AW-1:0]           where_reg;
    logic [AW-1:0]           k_reg;
    logic [HANDLE_BITS-1:0]  entry_reg;
    logic [HANDLE_BITS-1:0]  got_reg;
    logic [HANDLE_BITS-1:0]  rdata_reg;

    logic [plst_pkg::STATUS_W-1:0]    status_reg;
    logic [plst_pkg::ENTRY_W-1:0]     removed_reg;
    logic [plst_pkg::COUNT_OUT_W-1:0] count_out_reg;

    // decode of the incoming beat
    plst_pkg::op_t      op_in;
    logic [CMPW-1:0]    cnt_w, pos_w, where_w, k_w, wh_w;
    plst_pkg::status_t  st_new;
    plst_pkg::kind_t    kind_new;
    logic               list_full, list_empty;

    logic                   rd_en, wr_en;
    logic [AW-1:0]          rd_addr, wr_addr;
    logic [HANDLE_BITS-1:0] wr_data;
    logic                   is_ok;

    assign op_in      = plst_pkg::op_t'(operation);
    assign cnt_w      = CMPW'(count_reg);
    assign pos_w      = CMPW'(position);
    assign list_full  = (cnt_w == CMPW'(DEPTH));
    assign list_empty = (count_reg == '0);

    always_comb
    begin
        where_w  = '0;
        kind_new = plst_pkg::KIND_NONE;
        st_new   = plst_pkg::ST_OK;
        unique case (op_in)
            plst_pkg::OP_INS_FRONT:
            begin
                kind_new = plst_pkg::KIND_INSERT;
                where_w  = '0;
            end
            plst_pkg::OP_INS_BACK:
            begin
                kind_new = plst_pkg::KIND_INSERT;
                where_w  = cnt_w;
            end
            plst_pkg::OP_INS_AT:
            begin
                kind_new = plst_pkg::KIND_INSERT;
                where_w  = pos_w;
            end
            plst_pkg::OP_REM_FRONT:
            begin
                kind_new = plst_pkg::KIND_REMOVE;
                where_w  = '0;
            end
            plst_pkg::OP_REM_BACK:
            begin
                kind_new = plst_pkg::KIND_REMOVE;
                where_w  = list_empty ? '0 : cnt_w - CMPW'(1);
            end
            plst_pkg::OP_REM_AT:
            begin
                kind_new = plst_pkg::KIND_REMOVE;
                where_w  = pos_w;
            end
            plst_pkg::OP_READ_AT:
            begin
                kind_new = plst_pkg::KIND_READ;
                where_w  = pos_w;
            end
            default:
            begin
                kind_new = plst_pkg::KIND_NONE;
                where_w  = '0;
            end
        endcase

        // full and empty take precedence over a bad position
        if (kind_new == plst_pkg::KIND_INSERT)
        begin
            if (list_full)
                st_new = plst_pkg::ST_FULL;
            else if (where_w > cnt_w)
                st_new = plst_pkg::ST_BADPOS;
        end
        else if (kind_new != plst_pkg::KIND_NONE)
        begin
            if (list_empty)
                st_new = plst_pkg::ST_EMPTY;
            else if (where_w >= cnt_w)
                st_new = plst_pkg::ST_BADPOS;
        end
    end

    // shift progress
    assign is_ok = (st_reg == plst_pkg::ST_OK);
    assign k_w   = CMPW'(k_reg);
    assign wh_w  = CMPW'(where_reg);

    always_comb
    begin
        stat.ok   = is_ok;
        stat.kind = kind_reg;
        if (kind_reg == plst_pkg::KIND_INSERT)
        begin
            stat.move_more = (k_w > wh_w);
            stat.move_last = (k_w == wh_w + CMPW'(1));
        end
        else
        begin
            stat.move_more = (k_w + CMPW'(1) < cnt_w);
            stat.move_last = (k_w + CMPW'(2) == cnt_w);
        end
    end

    // count changes once per command, when the result is loaded
    always_comb
    begin
        count_next = count_reg;
        if (cmd.load_result && is_ok)
        begin
            if (kind_reg == plst_pkg::KIND_INSERT)
                count_next = count_reg + CW'(1);
            else if (kind_reg == plst_pkg::KIND_REMOVE)
                count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            kind_reg  <= plst_pkg::KIND_NONE;
            st_reg    <= plst_pkg::ST_OK;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.accept)
            begin
                kind_reg <= kind_new;
                st_reg   <= st_new;
            end
        end
    end

    // command payload, shift index and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            where_reg <= where_w[AW-1:0];
            k_reg     <= (kind_new == plst_pkg::KIND_INSERT) ? count_reg[AW-1:0]
                                                             : where_w[AW-1:0];
            entry_reg <= HANDLE_BITS'(entry);
            got_reg   <= '0;
        end
        else if (cmd.wr_move)
        begin
            k_reg <= (kind_reg == plst_pkg::KIND_INSERT) ? k_reg - AW'(1)
                                                         : k_reg + AW'(1);
        end
        if (cmd.keep_got)
            got_reg <= rdata_reg;
        if (cmd.load_result)
        begin
            status_reg    <= st_reg;
            removed_reg   <= is_ok ? plst_pkg::ENTRY_W'(got_reg) : '0;
            count_out_reg <= plst_pkg::COUNT_OUT_W'(count_next);
        end
    end

    // handle memory, one write and one registered read per cycle
    assign rd_en   = cmd.rd_target | cmd.rd_move;
    assign rd_addr = cmd.rd_target ? where_reg
                   : (kind_reg == plst_pkg::KIND_INSERT) ? k_reg - AW'(1)
                   : k_reg + AW'(1);
    assign wr_en   = cmd.wr_move | cmd.wr_place;
    assign wr_addr = cmd.wr_place ? where_reg : k_reg;
    assign wr_data = cmd.wr_place ? entry_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    assign status        = status_reg;
    assign removed_entry = removed_reg;
    assign entry_count   = count_out_reg;

    // count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_w <= CMPW'(DEPTH))
        else $error("list count above capacity");

    // count only moves when a result is loaded
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.load_result |=> $stable(count_reg))
        else $error("list count changed outside result load");

    // a shift write never happens past the target position
    a_move_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_move |-> stat.move_more)
        else $error("shift step beyond target position");

endmodule

FILE: sv/plst_ctrl.sv
// ----------------------------------------------------------------------------
// plst_ctrl: command sequencer for the positional list engine
// steps each command through fetch, shift, place and result load
// ----------------------------------------------------------------------------
module plst_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  plst_pkg::stat_t  stat,
    output plst_pkg::cmd_t   cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DECIDE  = 8'b0000_0010,
        S_FETCH   = 8'b0000_0100,
        S_GRAB    = 8'b0000_1000,
        S_MOVE_RD = 8'b0001_0000,
        S_MOVE_WR = 8'b0010_0000,
        S_PLACE   = 8'b0100_0000,
        S_FINISH  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!stat.ok || stat.kind == plst_pkg::KIND_NONE)
                    state_next = S_FINISH;
                else if (stat.kind == plst_pkg::KIND_INSERT)
                    state_next = stat.move_more ? S_MOVE_RD : S_PLACE;
                else
                    state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.rd_target = 1'b1;
                state_next    = S_GRAB;
            end
            S_GRAB:
            begin
                cmd.keep_got = 1'b1;
                if (stat.kind == plst_pkg::KIND_REMOVE && stat.move_more)
                    state_next = S_MOVE_RD;
                else
                    state_next = S_FINISH;
            end
            S_MOVE_RD:
            begin
                cmd.rd_move = 1'b1;
                state_next  = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                cmd.wr_move = 1'b1;
                if (!stat.move_last)
                    state_next = S_MOVE_RD;
                else if (stat.kind == plst_pkg::KIND_INSERT)
                    state_next = S_PLACE;
                else
                    state_next = S_FINISH;
            end
            S_PLACE:
            begin
                cmd.wr_place = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/positional_list_engine_top.sv
// ----------------------------------------------------------------------------
// positional_list_engine_top: ordered list of handles with positional access
// insert and remove at front, back or any position, plus read at position
// ----------------------------------------------------------------------------
// Keeps an ordered list of up to DEPTH handles of HANDLE_BITS bits, held in
// one memory with a single write and a single registered read per cycle.
// Every command beat gives exactly one result beat carrying a status, the
// removed or read handle, and the count after the command. Commands are taken
// one at a time; an insert or remove moves each later entry by one place, one
// entry at a time (memory read, then write). An insert moves count - position
// entries and then writes the new handle; a remove first reads the target
// entry and then moves count - 1 - position entries. Read-at only reads its
// entry, and rejected commands and the unused code go straight to the result
// load. The result sits in an output register, so the next command is taken
// while a result still waits for out_ready; a command only waits at its last
// step if the previous result was never taken.
// ----------------------------------------------------------------------------
module positional_list_engine_top #(
    parameter int DEPTH       = 64,
    parameter int HANDLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // command beat
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [plst_pkg::OP_W-1:0]         operation,
    input  logic [plst_pkg::POS_W-1:0]        position,
    input  logic [plst_pkg::ENTRY_W-1:0]      entry,

    // result beat
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [plst_pkg::STATUS_W-1:0]     status,
    output logic [plst_pkg::ENTRY_W-1:0]      removed_entry,
    output logic [plst_pkg::COUNT_OUT_W-1:0]  entry_count
);

    // sequencer commands and datapath progress flags
    plst_pkg::cmd_t  cmd;
    plst_pkg::stat_t stat;

    // sequencer: one command at a time, shift loop, output handshake
    plst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: decode and checks, handle memory, count, result register
    plst_dpath #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .operation     (operation),
        .position      (position),
        .entry         (entry),
        .cmd           (cmd),
        .stat          (stat),
        .status        (status),
        .removed_entry (removed_entry),
        .entry_count   (entry_count)
    );

endmodule
